// ----- rtl/core/opmac_pkg.sv -----
package opmac_pkg;

  // Tile geometry. Each may be set anywhere from 1 to 8.
  localparam int TILE_ROWS = 8;
  localparam int TILE_COLS = 8;

  // Lanes carried by the operand words and by a result row.
  localparam int LANES     = 8;
  localparam int LANE_W    = 8;
  localparam int ACC_W     = 32;
  localparam int PROD_W    = 2 * LANE_W;
  localparam int ROW_W     = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef acc_t [TILE_ROWS-1:0][TILE_COLS-1:0] tile_t;

  typedef struct packed {
    logic [63:0] a_column;
    logic [63:0] b_row;
    logic        final_k;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         row_index;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
    logic signed [31:0] value_4;
    logic signed [31:0] value_5;
    logic signed [31:0] value_6;
    logic signed [31:0] value_7;
    logic               last_row;
  } out_item_t;

  // Status of the result drain as seen by the input side.
  typedef struct packed {
    logic can_load;  // a new tile may be captured at this edge
  } drain_status_t;

endpackage

// ----- rtl/core/opmac_mac_array.sv -----
module opmac_mac_array (
  input  logic                 clk,
  input  logic                 rst_n,
  input  opmac_pkg::in_item_t  item,
  input  logic                 step,
  output opmac_pkg::tile_t     sum
);

  opmac_pkg::tile_t acc_r;
  opmac_pkg::tile_t acc_nxt;

  // One signed 8x8 multiply and one 32-bit add per accumulator.
  always_comb begin
    logic signed [opmac_pkg::LANE_W-1:0] av;
    logic signed [opmac_pkg::LANE_W-1:0] bv;
    logic signed [opmac_pkg::PROD_W-1:0] prod;
    av   = '0;
    bv   = '0;
    prod = '0;
    for (int r = 0; r < opmac_pkg::TILE_ROWS; r++) begin
      for (int c = 0; c < opmac_pkg::TILE_COLS; c++) begin
        av   = item.a_column[r*opmac_pkg::LANE_W +: opmac_pkg::LANE_W];
        bv   = item.b_row[c*opmac_pkg::LANE_W +: opmac_pkg::LANE_W];
        prod = av * bv;
        sum[r][c] = acc_r[r][c]
                  + {{(opmac_pkg::ACC_W-opmac_pkg::PROD_W){prod[opmac_pkg::PROD_W-1]}}, prod};
      end
    end
  end

  // The final step of a tile leaves the bank cleared for the next one.
  always_comb begin
    acc_nxt = acc_r;
    if (step) begin
      acc_nxt = item.final_k ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ----- rtl/core/opmac_drain.sv -----
module opmac_drain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  opmac_pkg::tile_t          tile,
  input  logic                      out_stall,
  output logic                      out_valid,
  output opmac_pkg::out_item_t      out_data,
  output opmac_pkg::drain_status_t  status
);

  opmac_pkg::tile_t            buf_r;
  logic                        busy_r, busy_nxt;
  logic [opmac_pkg::ROW_W-1:0] cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  opmac_pkg::out_item_t        out_r, out_nxt;
  logic                        slot_free;
  logic                        at_last;

  assign slot_free = !out_valid_r || !out_stall;
  assign at_last   = (cnt_r == opmac_pkg::ROW_W'(opmac_pkg::TILE_ROWS - 1));

  assign status.can_load = !busy_r || (at_last && slot_free);

  // Build the result row selected by the row counter.
  always_comb begin
    logic signed [31:0] vals [opmac_pkg::LANES];
    for (int c = 0; c < opmac_pkg::LANES; c++) begin
      vals[c] = '0;
    end
    for (int c = 0; c < opmac_pkg::TILE_COLS; c++) begin
      vals[c] = buf_r[cnt_r][c];
    end
    out_nxt           = out_r;
    out_nxt.row_index = 3'(cnt_r);
    out_nxt.value_0   = vals[0];
    out_nxt.value_1   = vals[1];
    out_nxt.value_2   = vals[2];
    out_nxt.value_3   = vals[3];
    out_nxt.value_4   = vals[4];
    out_nxt.value_5   = vals[5];
    out_nxt.value_6   = vals[6];
    out_nxt.value_7   = vals[7];
    out_nxt.last_row  = at_last;
  end

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (slot_free) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        cnt_nxt = cnt_r + opmac_pkg::ROW_W'(1);
        if (at_last) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= tile;
    end
    if (slot_free && busy_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/int8_outer_product_mac_tile.sv -----
// Signed int8 matrix tile engine: accumulates C = A*B into an 8x8 bank of
// int32 sums that wrap at 32 bits.
// Input channel (in_valid, in_stall, in_data): each transfer carries one
// column of A and one row of B for a single k, eight packed int8 each, and
// a final_k flag on the last k of the tile.
// Result channel (out_valid, out_stall, out_data): after a final_k transfer
// the block sends eight transfers, rows 0 to 7 in order, with last_row set
// on row 7. The accumulators are cleared as that tile is captured.
// Throughput is one input transfer per cycle while no final_k item waits: all
// 64 multiply-adds for one k are done between the input register and the
// accumulator bank. The first result row passes through the input register,
// the drain buffer and the output register, then one row per cycle follows
// while the receiver takes them; a further final_k item waits in the input
// register until the previous tile's last row has left the drain buffer.
// When the receiver stalls, the result held in the output register stays put
// and accumulation goes on until the next final_k item is reached.
// A synchronous reset (rst_n low) clears the accumulators and drops any
// pending item or result.
module int8_outer_product_mac_tile (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  opmac_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output opmac_pkg::out_item_t  out_data
);

  logic                      in_valid_r, in_valid_nxt;
  opmac_pkg::in_item_t       in_r;
  logic                      in_take;
  logic                      step;
  opmac_pkg::tile_t          sum;
  opmac_pkg::drain_status_t  drain_st;

  // The held item moves into the bank unless it closes a tile and the drain
  // buffer still holds rows of the previous one.
  assign step     = in_valid_r && (!in_r.final_k || drain_st.can_load);
  assign in_stall = in_valid_r && !step;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (step) begin
      in_valid_nxt = 1'b0;
    end
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
  end

  opmac_mac_array u_mac_array (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (in_r),
    .step  (step),
    .sum   (sum)
  );

  opmac_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && in_r.final_k),
    .tile      (sum),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (drain_st)
  );

endmodule
